[design/lbd_pkg.sv]
package lbd_pkg;

  localparam int SAMPLE_BITS = 10;
  localparam int NUM_RANGES  = 9;
  localparam int TABLE_LEN   = 9;
  localparam int THRESH_BITS = 8;
  localparam int NOISE_BITS  = 10;
  localparam int INDEX_BITS  = 4;

  localparam logic [THRESH_BITS-1:0] THRESH_RESET = THRESH_BITS'(10);
  localparam logic [NOISE_BITS-1:0]  NOISE_RESET  = NOISE_BITS'(100);
  localparam logic [THRESH_BITS-1:0] COUNT_MAX    = {THRESH_BITS{1'b1}};

  // Register word index, taken from paddr[2].
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_NOISE     = 1'b1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  // What the front end hands to the back end for one sample.
  typedef struct packed {
    logic                   check;   // reading accepted and above the noise floor
    logic [SAMPLE_BITS-1:0] sample;
  } lbd_mid_t;

  function automatic logic [SAMPLE_BITS-1:0] range_lo(input int i);
    logic [SAMPLE_BITS-1:0] v;
    case (i)
      0: v = SAMPLE_BITS'(943);
      1: v = SAMPLE_BITS'(859);
      2: v = SAMPLE_BITS'(745);
      3: v = SAMPLE_BITS'(440);
      4: v = SAMPLE_BITS'(265);
      5: v = SAMPLE_BITS'(143);
      6: v = SAMPLE_BITS'(988);
      7: v = SAMPLE_BITS'(802);
      8: v = SAMPLE_BITS'(345);
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] range_hi(input int i);
    logic [SAMPLE_BITS-1:0] v;
    case (i)
      0: v = SAMPLE_BITS'(948);
      1: v = SAMPLE_BITS'(865);
      2: v = SAMPLE_BITS'(755);
      3: v = SAMPLE_BITS'(451);
      4: v = SAMPLE_BITS'(275);
      5: v = SAMPLE_BITS'(155);
      6: v = SAMPLE_BITS'(997);
      7: v = SAMPLE_BITS'(813);
      8: v = SAMPLE_BITS'(358);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[design/lbd_front.sv]
module lbd_front import lbd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   take,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic [THRESH_BITS-1:0] debounce_threshold,
  input  logic [NOISE_BITS-1:0]  noise_floor,
  output lbd_mid_t               mid
);

  logic [SAMPLE_BITS-1:0] stable_value;
  logic [THRESH_BITS-1:0] disagree_count;
  logic [THRESH_BITS-1:0] count_next;
  logic                   accept;

  always_comb begin
    if (sample == stable_value) begin
      count_next = (disagree_count != '0) ? disagree_count - 1'b1 : disagree_count;
    end else begin
      count_next = (disagree_count != COUNT_MAX) ? disagree_count + 1'b1 : disagree_count;
    end
    accept     = (count_next >= debounce_threshold);
    mid.check  = accept && (SAMPLE_BITS'(noise_floor) < sample);
    mid.sample = sample;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stable_value   <= '0;
      disagree_count <= '0;
    end else if (take) begin
      if (accept) begin
        disagree_count <= '0;
        stable_value   <= sample;
      end else begin
        disagree_count <= count_next;
      end
    end
  end

endmodule

[design/lbd_queue.sv]
module lbd_queue import lbd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     wr_en,
  input  lbd_mid_t wr_data,
  input  logic     rd_en,
  output lbd_mid_t rd_data,
  output logic     full,
  output logic     empty
);

  lbd_mid_t             slots [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS:0]   count;

  assign full    = (count == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[design/lbd_back.sv]
module lbd_back import lbd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  lbd_mid_t              mid,
  input  logic                  mid_empty,
  output logic                  mid_pop,
  input  logic                  pop,
  output logic                  empty,
  output logic                  press_valid,
  output logic [INDEX_BITS-1:0] button_index
);

  logic                  out_full;
  logic                  hit;
  logic [INDEX_BITS-1:0] hit_index;

  // Walk the table from the top so that the lowest matching entry wins.
  always_comb begin
    hit       = 1'b0;
    hit_index = '0;
    for (int i = NUM_RANGES - 1; i >= 0; i--) begin
      if (i < TABLE_LEN && mid.sample >= range_lo(i) && mid.sample <= range_hi(i)) begin
        hit       = 1'b1;
        hit_index = INDEX_BITS'(i);
      end
    end
  end

  assign empty   = !out_full;
  assign mid_pop = !mid_empty && (!out_full || pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (mid_pop) begin
      out_full <= 1'b1;
    end else if (pop) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_pop) begin
      press_valid  <= mid.check && hit;
      button_index <= (mid.check && hit) ? hit_index : '0;
    end
  end

endmodule

[design/ladder_button_debounce_decode.sv]
// Debounces and decodes a resistor-ladder button line. Push one ADC sample per
// tick; every sample yields exactly one result, in order, with press_valid set
// when a newly accepted reading is above the noise floor and falls in one of
// the button ranges, and button_index naming the button or combination. A new
// sample is taken every cycle while full is low; the debounce decision and the
// range compare are each combinational, and a four-entry queue between them
// lets the input keep flowing while results wait. A result passes through a
// queue slot and the output register; up to five results can wait before full
// stops the input. The two registers sit on the APB port at byte addresses 0
// (debounce threshold) and 4 (noise floor); only paddr[2] selects the register.
module ladder_button_debounce_decode import lbd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  logic [SAMPLE_BITS-1:0] sample,
  output logic                   empty,
  input  logic                   pop,
  output logic                   press_valid,
  output logic [INDEX_BITS-1:0]  button_index,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  logic [THRESH_BITS-1:0] debounce_threshold;
  logic [NOISE_BITS-1:0]  noise_floor;
  lbd_mid_t               front_mid;
  lbd_mid_t               back_mid;
  logic                   take;
  logic                   mid_empty;
  logic                   mid_pop;
  logic                   cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign take      = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_threshold <= THRESH_RESET;
      noise_floor        <= NOISE_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_THRESHOLD: debounce_threshold <= pwdata[THRESH_BITS-1:0];
        REG_NOISE:     noise_floor        <= pwdata[NOISE_BITS-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_THRESHOLD: prdata = {{(32-THRESH_BITS){1'b0}}, debounce_threshold};
      REG_NOISE:     prdata = {{(32-NOISE_BITS){1'b0}}, noise_floor};
      default:       prdata = '0;
    endcase
  end

  lbd_front u_front (
    .clk                (clk),
    .rst                (rst),
    .take               (take),
    .sample             (sample),
    .debounce_threshold (debounce_threshold),
    .noise_floor        (noise_floor),
    .mid                (front_mid)
  );

  lbd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (take),
    .wr_data (front_mid),
    .rd_en   (mid_pop),
    .rd_data (back_mid),
    .full    (full),
    .empty   (mid_empty)
  );

  lbd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .mid          (back_mid),
    .mid_empty    (mid_empty),
    .mid_pop      (mid_pop),
    .pop          (pop),
    .empty        (empty),
    .press_valid  (press_valid),
    .button_index (button_index)
  );

endmodule
